// ----- hdl/ook_pkg.sv -----
package ook_pkg;

    // Field widths fixed by the item and register formats
    localparam int CODE_IN_W   = 12;
    localparam int UNIT_W      = 16;
    localparam int REPEAT_W    = 4;
    localparam int GAP_W       = 6;
    localparam int UNITS_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SLOT_W      = 2;

    localparam int DEF_CODE_BITS = 12;

    // Register reset values
    localparam logic [UNIT_W-1:0]   RST_UNIT_TICKS   = 16'd330;
    localparam logic [REPEAT_W-1:0] RST_REPEAT_COUNT = 4'd10;
    localparam logic [GAP_W-1:0]    RST_GAP_UNITS    = 6'd31;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_UNITS    = 2'd2;

    // Item operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Pulse slot codes
    localparam logic [SLOT_W-1:0] SLOT_FIRST = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_DATA  = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_TRAIL = 2'd2;

    // Half-pulse lengths in units
    localparam logic [UNITS_W-1:0] UNITS_ONE   = 6'd1;
    localparam logic [UNITS_W-1:0] UNITS_THREE = 6'd3;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit_ticks;
        logic [REPEAT_W-1:0] repeat_count;
        logic [GAP_W-1:0]    gap_units;
    } t_cfg;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic start_rejected;
    } t_result;

endpackage

// ----- hdl/ook_if.sv -----
interface ook_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [ook_pkg::CODE_IN_W-1:0] code_word;

    modport source (output valid, output op, output code_word, input ready);
    modport sink   (input valid, input op, input code_word, output ready);
endinterface

interface ook_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic start_rejected;

    modport source (output valid, output line_level, output busy_res,
                    output frame_done, output start_rejected, input ready);
    modport sink   (input valid, input line_level, input busy_res,
                    input frame_done, input start_rejected, output ready);
endinterface

interface ook_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ook_pkg::CFG_IDX_W-1:0]  index;
    logic [ook_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/ook_cfg.sv -----
module ook_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [ook_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [ook_pkg::CFG_DATA_W-1:0] i_data,
    output ook_pkg::t_cfg                  o_cfg
);
    import ook_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_ticks   <= RST_UNIT_TICKS;
            r_cfg.repeat_count <= RST_REPEAT_COUNT;
            r_cfg.gap_units    <= RST_GAP_UNITS;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_UNIT_TICKS:   r_cfg.unit_ticks   <= i_data[UNIT_W-1:0];
                CFG_REPEAT_COUNT: r_cfg.repeat_count <= i_data[REPEAT_W-1:0];
                CFG_GAP_UNITS:    r_cfg.gap_units    <= i_data[GAP_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/ook_seq.sv -----
module ook_seq #(
    parameter int CODE_BITS = ook_pkg::DEF_CODE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_op,
    input  logic [ook_pkg::CODE_IN_W-1:0] i_code_word,
    input  ook_pkg::t_cfg                 i_cfg,
    output ook_pkg::t_result              o_res
);
    import ook_pkg::*;

    localparam int BIT_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(CODE_BITS - 1);

    logic                 r_sending,  n_sending;
    logic [CODE_BITS-1:0] r_code,     n_code;
    logic [BIT_W-1:0]     r_bitpos,   n_bitpos;
    logic [SLOT_W-1:0]    r_slot,     n_slot;
    logic                 r_low,      n_low;
    logic [UNITS_W-1:0]   r_units,    n_units;
    logic [UNIT_W-1:0]    r_tick,     n_tick;
    logic [REPEAT_W-1:0]  r_repeats,  n_repeats;
    logic                 r_pin,      n_pin;

    logic              cur_bit;
    logic [UNIT_W-1:0] tick_inc;
    logic              done;
    logic              rejected;

    assign cur_bit  = r_code[r_bitpos];
    assign tick_inc = r_tick + 1'b1;

    always_comb begin
        n_sending = r_sending;
        n_code    = r_code;
        n_bitpos  = r_bitpos;
        n_slot    = r_slot;
        n_low     = r_low;
        n_units   = r_units;
        n_tick    = r_tick;
        n_repeats = r_repeats;
        n_pin     = r_pin;
        done      = 1'b0;
        rejected  = 1'b0;

        if (i_op == OP_START) begin
            if (r_sending) begin
                rejected = 1'b1;
            end else begin
                n_code    = CODE_BITS'({{CODE_BITS{1'b0}}, i_code_word});
                n_sending = 1'b1;
                n_repeats = i_cfg.repeat_count;
                n_bitpos  = LAST_BIT;
                n_slot    = SLOT_FIRST;
                n_low     = 1'b1;
                n_pin     = 1'b0;
                n_units   = UNITS_ONE;
                n_tick    = '0;
            end
        end else if (r_sending) begin
            if (r_units != '0) begin
                // count ticks inside the current unit
                if (tick_inc == i_cfg.unit_ticks) begin
                    n_tick  = '0;
                    n_units = r_units - 1'b1;
                end else begin
                    n_tick = tick_inc;
                end
            end else if (r_low) begin
                // low half finished: go high
                n_low  = 1'b0;
                n_pin  = 1'b1;
                n_tick = '0;
                unique case (r_slot)
                    SLOT_FIRST: n_units = UNITS_THREE;
                    SLOT_DATA:  n_units = cur_bit ? UNITS_THREE : UNITS_ONE;
                    default:    n_units = UNITS_W'(i_cfg.gap_units);
                endcase
            end else begin
                n_tick = '0;
                unique case (r_slot)
                    SLOT_FIRST: begin
                        n_slot  = SLOT_DATA;
                        n_low   = 1'b1;
                        n_pin   = 1'b0;
                        n_units = cur_bit ? UNITS_ONE : UNITS_THREE;
                    end
                    SLOT_DATA: begin
                        if (r_bitpos != '0) begin
                            n_bitpos = r_bitpos - 1'b1;
                            n_slot   = SLOT_FIRST;
                        end else begin
                            n_slot = SLOT_TRAIL;
                        end
                        n_low   = 1'b1;
                        n_pin   = 1'b0;
                        n_units = UNITS_ONE;
                    end
                    default: begin
                        if (r_repeats <= REPEAT_W'(1)) begin
                            n_sending = 1'b0;
                            n_repeats = '0;
                            n_pin     = 1'b1;
                            n_low     = 1'b0;
                            n_units   = '0;
                            n_slot    = SLOT_FIRST;
                            done      = 1'b1;
                        end else begin
                            n_repeats = r_repeats - 1'b1;
                            n_bitpos  = LAST_BIT;
                            n_slot    = SLOT_FIRST;
                            n_low     = 1'b1;
                            n_pin     = 1'b0;
                            n_units   = UNITS_ONE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending <= 1'b0;
            r_code    <= '0;
            r_bitpos  <= '0;
            r_slot    <= SLOT_FIRST;
            r_low     <= 1'b0;
            r_units   <= '0;
            r_tick    <= '0;
            r_repeats <= '0;
            r_pin     <= 1'b1;
        end else if (i_fire) begin
            r_sending <= n_sending;
            r_code    <= n_code;
            r_bitpos  <= n_bitpos;
            r_slot    <= n_slot;
            r_low     <= n_low;
            r_units   <= n_units;
            r_tick    <= n_tick;
            r_repeats <= n_repeats;
            r_pin     <= n_pin;
        end
    end

    assign o_res.line_level     = n_pin;
    assign o_res.busy_res       = n_sending;
    assign o_res.frame_done     = done;
    assign o_res.start_rejected = rejected;

endmodule

// ----- hdl/ook_oreg.sv -----
module ook_oreg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ook_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output ook_pkg::t_result o_res
);
    import ook_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held result is being taken this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- hdl/ook_remote_code_transmitter_core.sv -----
// On-off-keyed remote-code transmitter, paced by timer ticks. Each input
// transfer is either a tick or a start carrying a 12-bit code; each one
// yields exactly one result transfer giving the pin level after that item,
// the busy flag, a frame-done strobe on the tick that ends the last repeat,
// and a start-rejected flag for a start that arrived while busy. The code
// is sent MSB first, repeat_count times; each bit is a 1-low/3-high pair
// followed by a 1-low/3-high pair for a one or 3-low/1-high for a zero,
// and each repeat ends with 1 unit low and gap_units high. A half-pulse of
// m units lasts m*unit_ticks+1 ticks; unit_ticks of zero counts as 65536.
// Rate: one item per clock cycle while the output register is free. The
// sequencer updates its counters as the item is taken and the result lands
// in a single output register, valid in the cycle after; input ready drops
// only while it is full and not taken. Write configuration only while idle.
module ook_remote_code_transmitter_core #(
    parameter int CODE_BITS = ook_pkg::DEF_CODE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ook_in_if.sink    i_in,
    ook_cfg_if.sink   i_cfg,
    ook_out_if.source o_out
);
    import ook_pkg::*;

    t_cfg    cfg;
    t_result seq_res;
    t_result out_res;
    logic    in_fire;
    logic    oreg_free;
    logic    out_valid;

    // Configuration writes are always accepted
    assign i_cfg.ready = 1'b1;

    ook_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    // Take an item whenever the output register can hold its result
    assign i_in.ready = oreg_free;
    assign in_fire    = i_in.valid && oreg_free;

    ook_seq #(
        .CODE_BITS (CODE_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_op        (i_in.op),
        .i_code_word (i_in.code_word),
        .i_cfg       (cfg),
        .o_res       (seq_res)
    );

    ook_oreg u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_fire),
        .i_res   (seq_res),
        .i_ready (o_out.ready),
        .o_free  (oreg_free),
        .o_valid (out_valid),
        .o_res   (out_res)
    );

    assign o_out.valid          = out_valid;
    assign o_out.line_level     = out_res.line_level;
    assign o_out.busy_res       = out_res.busy_res;
    assign o_out.frame_done     = out_res.frame_done;
    assign o_out.start_rejected = out_res.start_rejected;

endmodule

// ----- test/ook_remote_code_transmitter_core_tb.sv -----
module ook_remote_code_transmitter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ook_pkg::*;

    localparam int CODE_BITS   = DEF_CODE_BITS;
    localparam int STALL_LIMIT = 2000;
    // Random items to run after the directed table; short units and few
    // repeats keep each phase small so the whole run stays near its budget
    localparam int RANDOM_ITEMS = 550;
    // Ticks run with a unit of zero: far short of the 65536 + 1 ticks the
    // first low half needs, so the line must stay low throughout
    localparam int WRAP_TICKS = 64;

    // Index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Results that can be read straight off the behaviour
    localparam t_result R_IDLE = '{line_level: 1'b1, busy_res: 1'b0,
                                   frame_done: 1'b0, start_rejected: 1'b0};
    localparam t_result R_SEND = '{line_level: 1'b0, busy_res: 1'b1,
                                   frame_done: 1'b0, start_rejected: 1'b0};
    localparam t_result R_REJ  = '{line_level: 1'b0, busy_res: 1'b1,
                                   frame_done: 1'b0, start_rejected: 1'b1};

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_DRAIN} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   op;
        logic [CODE_IN_W-1:0]   code;
        logic                   typed;
        t_result                want;
    } t_row;

    localparam int PLAN_LEN = 19;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ook_in_if  in_if ();
    ook_out_if out_if ();
    ook_cfg_if cfg_if ();

    ook_remote_code_transmitter_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    // Register copies held by the predictor
    logic [UNIT_W-1:0]   cfg_unit;
    logic [REPEAT_W-1:0] cfg_repeat;
    logic [GAP_W-1:0]    cfg_gap;

    // Transmitter state held by the predictor
    logic                tx_busy;
    logic [CODE_IN_W-1:0] tx_code;
    logic [3:0]          tx_bit;
    logic [SLOT_W-1:0]   tx_slot;
    logic                tx_low;
    logic [UNITS_W-1:0]  tx_units;
    logic [UNIT_W-1:0]   tx_tick;
    logic [REPEAT_W-1:0] tx_repeats;
    logic                tx_pin;

    // Pin results still owed by the block, oldest first
    t_result pin_results_q [$];

    int  item_count;
    int  mismatches;
    int  quiet_cycles = 0;
    bit  jitter_on;
    int  stall_left;
    t_result mon_got;
    t_result mon_want;
    t_row plan [PLAN_LEN];

    // Open a half-pulse: a low half drops the pin, a high half raises it
    function automatic void open_half(input logic low, input logic [UNITS_W-1:0] units);
        tx_low   = low;
        tx_pin   = ~low;
        tx_units = units;
        tx_tick  = '0;
    endfunction

    // Advance the transmitter by one item and return the pin result it gives
    function automatic t_result predict_pin_item(input logic op,
                                                 input logic [CODE_IN_W-1:0] code);
        t_result r;
        logic    done;
        logic    rej;
        logic    cur;
        done = 1'b0;
        rej  = 1'b0;
        if (op == OP_START) begin
            if (tx_busy) begin
                // A start while busy is dropped and flagged; no tick passes
                rej = 1'b1;
            end else begin
                tx_code    = code;
                tx_busy    = 1'b1;
                tx_repeats = cfg_repeat;
                tx_bit     = 4'(CODE_BITS - 1);
                tx_slot    = SLOT_FIRST;
                open_half(1'b1, UNITS_ONE);
            end
        end else if (tx_busy) begin
            cur = tx_code[tx_bit];
            if (tx_units != '0) begin
                // Count ticks within the unit; a unit of zero wraps at 65536
                tx_tick = tx_tick + 1'b1;
                if (tx_tick == cfg_unit) begin
                    tx_tick  = '0;
                    tx_units = tx_units - 1'b1;
                end
            end else if (tx_low) begin
                if (tx_slot == SLOT_FIRST)
                    open_half(1'b0, UNITS_THREE);
                else if (tx_slot == SLOT_DATA)
                    open_half(1'b0, cur ? UNITS_THREE : UNITS_ONE);
                else
                    open_half(1'b0, UNITS_W'(cfg_gap));
            end else if (tx_slot == SLOT_FIRST) begin
                tx_slot = SLOT_DATA;
                open_half(1'b1, cur ? UNITS_ONE : UNITS_THREE);
            end else if (tx_slot == SLOT_DATA) begin
                if (tx_bit != '0) begin
                    tx_bit  = tx_bit - 1'b1;
                    tx_slot = SLOT_FIRST;
                end else begin
                    tx_slot = SLOT_TRAIL;
                end
                open_half(1'b1, UNITS_ONE);
            end else if (tx_repeats <= 4'd1) begin
                // Last repeat over: a repeat count of zero ends here too
                tx_busy    = 1'b0;
                tx_repeats = '0;
                tx_slot    = SLOT_FIRST;
                open_half(1'b0, '0);
                done = 1'b1;
            end else begin
                tx_repeats = tx_repeats - 1'b1;
                tx_bit     = 4'(CODE_BITS - 1);
                tx_slot    = SLOT_FIRST;
                open_half(1'b1, UNITS_ONE);
            end
        end
        r.line_level     = tx_pin;
        r.busy_res       = tx_busy;
        r.frame_done     = done;
        r.start_rejected = rej;
        return r;
    endfunction

    // Drive one item and hold it until the transfer; valid stays high after
    // the transfer so that back-to-back items follow one another with no gap
    task automatic push_item(input logic op, input logic [CODE_IN_W-1:0] code,
                             input logic typed, input t_result want);
        t_result got;
        int      gap;
        if (jitter_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 15);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.code_word <= code;
        do @(posedge i_clk); while (!in_if.ready);
        got = predict_pin_item(op, code);
        pin_results_q.push_back(typed ? want : got);
        item_count++;
    endtask

    // Drop valid and hold the sender back until every result has come
    task automatic quiesce();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pin_results_q.size() != 0);
    endtask

    // One register write; the trailing cycle keeps a single update of valid
    // per time step when writes follow one another
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_UNIT_TICKS:   cfg_unit   = data;
            CFG_REPEAT_COUNT: cfg_repeat = data[REPEAT_W-1:0];
            CFG_GAP_UNITS:    cfg_gap    = data[GAP_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Tick until the current transmission has run out
    task automatic drain_frame();
        while (tx_busy)
            push_item(OP_TICK, CODE_IN_W'($urandom), 1'b0, R_IDLE);
    endtask

    task automatic report(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("%t %s: line/busy/done/rej expected %b/%b/%b/%b got %b/%b/%b/%b",
                     $realtime, what,
                     want.line_level, want.busy_res, want.frame_done, want.start_rejected,
                     got.line_level, got.busy_res, got.frame_done, got.start_rejected);
    endtask

    // Result side: stall in bursts while jitter is on, otherwise always ready
    initial begin
        out_if.ready <= 1'b1;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0)
                    out_if.ready <= 1'b1;
            end else if (jitter_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 15);
                out_if.ready <= 1'b0;
            end
        end
    end

    // Compare each result transfer with the oldest owed pin result
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            mon_got = {out_if.line_level, out_if.busy_res,
                       out_if.frame_done, out_if.start_rejected};
            if (pin_results_q.size() == 0) begin
                report("result with nothing owed", '0, mon_got);
            end else begin
                mon_want = pin_results_q.pop_front();
                if (mon_got.line_level !== mon_want.line_level ||
                    mon_got.busy_res !== mon_want.busy_res ||
                    mon_got.frame_done !== mon_want.frame_done ||
                    mon_got.start_rejected !== mon_want.start_rejected)
                    report("result mismatch", mon_want, mon_got);
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** ook_remote_code_transmitter_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int random_start;
        int frames;
        int ticks;
        logic [UNIT_W-1:0]   unit;
        logic [REPEAT_W-1:0] reps;
        logic [GAP_W-1:0]    gap;
        logic [CODE_IN_W-1:0] code;

        // Hold every input at a known value from the start
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.op        <= OP_TICK;
        in_if.code_word <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= CFG_UNIT_TICKS;
        cfg_if.data     <= '0;
        item_count      = 0;
        mismatches      = 0;
        jitter_on       = 1'b1;

        cfg_unit   = RST_UNIT_TICKS;
        cfg_repeat = RST_REPEAT_COUNT;
        cfg_gap    = RST_GAP_UNITS;
        tx_busy    = 1'b0;
        tx_code    = '0;
        tx_bit     = '0;
        tx_slot    = SLOT_FIRST;
        tx_low     = 1'b0;
        tx_units   = '0;
        tx_tick    = '0;
        tx_repeats = '0;
        tx_pin     = 1'b1;

        // Directed table: idle ticks, register extremes and masking, the
        // spare index, a repeat count and gap of zero, a start while busy,
        // all-ones and all-zeros codes, and two repeats with the longest gap
        plan = '{
            '{ROW_ITEM,  CFG_UNIT_TICKS,   16'h0000, OP_TICK,  12'hFFF, 1'b1, R_IDLE},
            '{ROW_CFG,   CFG_UNIT_TICKS,   16'hFFFF, OP_TICK,  12'h000, 1'b0, R_IDLE},
            '{ROW_ITEM,  CFG_UNIT_TICKS,   16'h0000, OP_TICK,  12'h000, 1'b1, R_IDLE},
            '{ROW_CFG,   CFG_UNIT_TICKS,   16'h0001, OP_TICK,  12'h000, 1'b0, R_IDLE},
            '{ROW_CFG,   CFG_REPEAT_COUNT, 16'hFFF0, OP_TICK,  12'h000, 1'b0, R_IDLE},
            '{ROW_CFG,   CFG_GAP_UNITS,    16'hFFC0, OP_TICK,  12'h000, 1'b0, R_IDLE},
            '{ROW_CFG,   CFG_SPARE,        16'hFFFF, OP_TICK,  12'h000, 1'b0, R_IDLE},
            '{ROW_ITEM,  CFG_UNIT_TICKS,   16'h0000, OP_START, 12'hFFF, 1'b1, R_SEND},
            '{ROW_ITEM,  CFG_UNIT_TICKS,   16'h0000, OP_START, 12'h000, 1'b1, R_REJ},
            '{ROW_ITEM,  CFG_UNIT_TICKS,   16'h0000, OP_TICK,  12'h555, 1'b0, R_IDLE},
            '{ROW_ITEM,  CFG_UNIT_TICKS,   16'h0000, OP_TICK,  12'hAAA, 1'b0, R_IDLE},
            '{ROW_DRAIN, CFG_UNIT_TICKS,   16'h0000, OP_TICK,  12'h000, 1'b0, R_IDLE},
            '{ROW_ITEM,  CFG_UNIT_TICKS,   16'h0000, OP_TICK,  12'h000, 1'b1, R_IDLE},
            '{ROW_CFG,   CFG_REPEAT_COUNT, 16'h0002, OP_TICK,  12'h000, 1'b0, R_IDLE},
            '{ROW_CFG,   CFG_GAP_UNITS,    16'h003F, OP_TICK,  12'h000, 1'b0, R_IDLE},
            '{ROW_ITEM,  CFG_UNIT_TICKS,   16'h0000, OP_START, 12'h000, 1'b1, R_SEND},
            '{ROW_ITEM,  CFG_UNIT_TICKS,   16'h0000, OP_START, 12'hFFF, 1'b1, R_REJ},
            '{ROW_DRAIN, CFG_UNIT_TICKS,   16'h0000, OP_TICK,  12'h000, 1'b0, R_IDLE},
            '{ROW_ITEM,  CFG_UNIT_TICKS,   16'h0000, OP_TICK,  12'hFFF, 1'b1, R_IDLE}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; registers change only once all is quiet
        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CFG: begin
                    quiesce();
                    write_reg(plan[i].idx, plan[i].data);
                end
                ROW_ITEM:  push_item(plan[i].op, plan[i].code, plan[i].typed, plan[i].want);
                ROW_DRAIN: drain_frame();
                default: ;
            endcase
        end

        // Random phases: each writes all three registers, with noise in the
        // unused data bits, then sends one or two whole frames with the odd
        // start thrown in while busy and a few idle ticks between frames
        random_start = item_count;
        while (item_count - random_start < RANDOM_ITEMS) begin
            quiesce();
            jitter_on = ($urandom_range(0, 3) != 0);
            unit = ($urandom_range(0, 3) == 0) ? UNIT_W'($urandom_range(2, 3))
                                               : UNIT_W'(1);
            reps = REPEAT_W'($urandom_range(1, 2));
            gap  = GAP_W'($urandom_range(0, 31));
            write_reg(CFG_UNIT_TICKS, unit);
            write_reg(CFG_REPEAT_COUNT, {12'($urandom), reps});
            write_reg(CFG_GAP_UNITS, {10'($urandom), gap});
            frames = ($urandom_range(0, 3) == 0) ? 2 : 1;
            repeat (frames) begin
                ticks = $urandom_range(0, 3);
                repeat (ticks)
                    push_item(OP_TICK, CODE_IN_W'($urandom), 1'b0, R_IDLE);
                code = ($urandom_range(0, 7) == 0) ?
                       (($urandom_range(0, 1) == 0) ? 12'h000 : 12'hFFF) :
                       CODE_IN_W'($urandom);
                push_item(OP_START, code, 1'b0, R_IDLE);
                while (tx_busy) begin
                    if ($urandom_range(0, 24) == 0)
                        push_item(OP_START, CODE_IN_W'($urandom), 1'b0, R_IDLE);
                    else
                        push_item(OP_TICK, CODE_IN_W'($urandom), 1'b0, R_IDLE);
                end
            end
        end

        // Last part, no idling on either side: a unit of zero counts as
        // 65536 ticks, so the line holds low for every tick sent here and
        // the run stops mid-frame
        quiesce();
        jitter_on = 1'b0;
        write_reg(CFG_UNIT_TICKS, 16'h0000);
        write_reg(CFG_REPEAT_COUNT, 16'h000F);
        write_reg(CFG_GAP_UNITS, 16'h003F);
        push_item(OP_START, CODE_IN_W'($urandom), 1'b0, R_IDLE);
        repeat (WRAP_TICKS)
            push_item(OP_TICK, CODE_IN_W'($urandom), 1'b0, R_IDLE);

        // Wait for the last results, then allow the block's latency to pass
        quiesce();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && pin_results_q.size() == 0) begin
            $display("** ook_remote_code_transmitter_core: PASSED **");
        end else begin
            $display("** ook_remote_code_transmitter_core: FAILED **");
        end
        $finish;
    end

endmodule
